// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// antecedent in one cycle forces the consequent in the next
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/imh_pkg.sv =====
package imh_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_CHANGE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_EXTRACT = 3'd3,
    CMD_PEEK    = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_EX,
    ST_EX_RD,
    ST_RM,
    ST_RM_RD,
    ST_UP,
    ST_UP_CMP,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_FIN
  } state_t;

  // beat layout
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;
  localparam int SYM_W      = 16;
  localparam int CNT_OUT_W  = 24;
  localparam int ENT_W      = 11;
  localparam int CHG_W      = 16;

endpackage

// ===== rtl/core/imh_ram.sv =====
module imh_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/indexed_max_heap_pair_counts.sv =====
// indexed max-heap of pair counts, one command per beat, one result beat per command
// keyed commands first scan the heap for their key, one entry a cycle,
// then a sift moves the entry up or down over up to log2(HEAP_DEPTH) levels
// extract and peek skip the scan; the one read port of the heap memory paces the scan and the sifts
// throughput: one command at a time, the next beat is taken once the result is queued
// reset clears the entry count and the handshakes; heap memory needs no clearing pass
`include "assert_macros.svh"

module indexed_max_heap_pair_counts #(
  parameter int HEAP_DEPTH  = 1024,
  parameter int SYMBOL_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd[2:0], key_first[18:3], key_second[34:19], change_amount[50:35]
  input  logic [imh_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], count_out[25:2], key_first_out[41:26], key_second_out[57:42],
  // entries[68:58]
  output logic [imh_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import imh_pkg::*;

  localparam int PW = $clog2(HEAP_DEPTH);
  localparam int SW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = 2 * SYMBOL_BITS;
  localparam int EW = KW + COUNT_BITS;
  localparam int NW = ((COUNT_BITS > CHG_W) ? COUNT_BITS : CHG_W) + 2;
  localparam int XW = PW + 2;

  state_t                 state_r, state_nxt;
  logic [SW-1:0]          size_r, size_nxt;
  logic [PW-1:0]          p_r, p_nxt;
  logic [SW-1:0]          scan_r, scan_nxt;
  logic                   pend_r, pend_nxt;
  logic [PW-1:0]          cpos_r, cpos_nxt;
  logic [EW-1:0]          elem_r, elem_nxt;
  logic [EW-1:0]          left_r, left_nxt;
  logic                   down_r, down_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [KW-1:0]          key_r, key_nxt;
  logic signed [CHG_W-1:0] chg_r, chg_nxt;
  status_t                st_r, st_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [SYMBOL_BITS-1:0] kfo_r, kfo_nxt;
  logic [SYMBOL_BITS-1:0] kso_r, kso_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [PW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [PW-1:0]          ram_raddr;
  logic [EW-1:0]          rd;

  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [KW-1:0]          rd_key;
  logic [COUNT_BITS-1:0]  e_cnt;
  logic [COUNT_BITS-1:0]  l_cnt;
  logic [COUNT_BITS-1:0]  inc_cnt;
  logic signed [NW-1:0]   nv;
  logic                   nv_le0;
  logic [COUNT_BITS-1:0]  nv_sat;
  logic [XW-1:0]          lidx;
  logic [XW-1:0]          ridx;
  logic [XW-1:0]          size_x;
  logic [PW-1:0]          par;
  logic                   match;
  logic [SW-1:0]          last;
  cmd_t                   cmd_in;

  imh_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // entry fields and arithmetic helpers
  assign rd_cnt  = rd[COUNT_BITS-1:0];
  assign rd_key  = rd[EW-1:COUNT_BITS];
  assign e_cnt   = elem_r[COUNT_BITS-1:0];
  assign l_cnt   = left_r[COUNT_BITS-1:0];
  assign inc_cnt = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + 1'b1;
  assign nv      = $signed(NW'(rd_cnt)) + NW'(chg_r);
  assign nv_le0  = nv[NW-1] || (nv == '0);
  assign nv_sat  = (nv > $signed(NW'({COUNT_BITS{1'b1}}))) ? {COUNT_BITS{1'b1}}
                                                           : COUNT_BITS'(nv);
  assign lidx    = XW'({p_r, 1'b1});
  assign ridx    = XW'({p_r, 1'b0}) + XW'(2);
  assign size_x  = XW'(size_r);
  assign par     = PW'((p_r - 1'b1) >> 1);
  assign match   = pend_r && (rd_key == key_r);
  assign last    = size_r - 1'b1;
  assign cmd_in  = cmd_t'(in_tdata[2:0]);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    p_nxt         = p_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    cpos_nxt      = cpos_r;
    elem_nxt      = elem_r;
    left_nxt      = left_r;
    down_nxt      = down_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    chg_nxt       = chg_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    kfo_nxt       = kfo_r;
    kso_nxt       = kso_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = p_r;
    ram_wdata     = elem_r;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = cmd_in;
          key_nxt  = {SYMBOL_BITS'(in_tdata[18:3]), SYMBOL_BITS'(in_tdata[34:19])};
          chg_nxt  = $signed(in_tdata[50:35]);
          st_nxt   = STAT_OK;
          cnt_nxt  = '0;
          kfo_nxt  = '0;
          kso_nxt  = '0;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          unique case (cmd_in)
            CMD_INSERT, CMD_CHANGE, CMD_DELETE: state_nxt = ST_SRCH;
            CMD_EXTRACT, CMD_PEEK: begin
              if (size_r == '0) begin
                st_nxt    = STAT_EMPTY;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_EX;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      // linear key scan, one read a cycle
      ST_SRCH: begin
        ram_raddr = PW'(scan_r);
        if (match) begin
          p_nxt    = cpos_r;
          down_nxt = 1'b0;
          unique case (cmd_r)
            CMD_INSERT: begin
              elem_nxt  = {key_r, inc_cnt};
              cnt_nxt   = inc_cnt;
              state_nxt = ST_UP;
            end
            CMD_CHANGE: begin
              if (nv_le0) begin
                state_nxt = ST_RM;
              end else begin
                elem_nxt  = {key_r, nv_sat};
                cnt_nxt   = nv_sat;
                state_nxt = chg_r[CHG_W-1] ? ST_DN : ST_UP;
              end
            end
            default: begin
              cnt_nxt   = rd_cnt;
              state_nxt = ST_RM;
            end
          endcase
        end else if (scan_r < size_r) begin
          pend_nxt = 1'b1;
          cpos_nxt = PW'(scan_r);
          scan_nxt = scan_r + 1'b1;
        end else if (cmd_r == CMD_INSERT) begin
          if (size_r == SW'(HEAP_DEPTH)) begin
            st_nxt    = STAT_FULL;
            state_nxt = ST_FIN;
          end else begin
            elem_nxt  = {key_r, COUNT_BITS'(1)};
            cnt_nxt   = COUNT_BITS'(1);
            p_nxt     = PW'(size_r);
            size_nxt  = size_r + 1'b1;
            down_nxt  = 1'b0;
            state_nxt = ST_UP;
          end
        end else begin
          st_nxt    = STAT_NOTFOUND;
          state_nxt = ST_FIN;
        end
      end

      // read the root for extract and peek
      ST_EX: begin
        ram_raddr = '0;
        state_nxt = ST_EX_RD;
      end

      ST_EX_RD: begin
        cnt_nxt = rd_cnt;
        kfo_nxt = rd_key[KW-1:SYMBOL_BITS];
        kso_nxt = rd_key[SYMBOL_BITS-1:0];
        if (cmd_r == CMD_EXTRACT) begin
          p_nxt     = '0;
          state_nxt = ST_RM;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // removal: unless the hole is the last entry, the last entry fills the hole, then sifts up and down
      ST_RM: begin
        ram_raddr = PW'(last);
        if (SW'(p_r) == last) begin
          size_nxt  = last;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RM_RD;
        end
      end

      ST_RM_RD: begin
        elem_nxt  = rd;
        size_nxt  = last;
        down_nxt  = 1'b1;
        state_nxt = ST_UP;
      end

      // sift up, held entry stays in elem_r until its place is known
      ST_UP: begin
        ram_raddr = par;
        if (p_r == '0) begin
          if (down_r) begin
            state_nxt = ST_DN;
          end else begin
            ram_we    = 1'b1;
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        if (rd_cnt < e_cnt) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          p_nxt     = par;
          state_nxt = ST_UP;
        end else if (down_r) begin
          state_nxt = ST_DN;
        end else begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end
      end

      // sift down, left child then right child
      ST_DN: begin
        ram_raddr = PW'(lidx);
        if (lidx >= size_x) begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DN_L;
        end
      end

      ST_DN_L: begin
        left_nxt  = rd;
        ram_raddr = PW'(ridx);
        if (ridx < size_x) begin
          state_nxt = ST_DN_R;
        end else if (e_cnt < rd_cnt) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          p_nxt     = PW'(lidx);
          state_nxt = ST_DN;
        end else begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end
      end

      // ties go right unless the left child is strictly larger
      ST_DN_R: begin
        ram_we = 1'b1;
        if ((l_cnt > rd_cnt) && (e_cnt < l_cnt)) begin
          ram_wdata = left_r;
          p_nxt     = PW'(lidx);
          state_nxt = ST_DN;
        end else if (e_cnt < rd_cnt) begin
          ram_wdata = rd;
          p_nxt     = PW'(ridx);
          state_nxt = ST_DN;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // hand the result to the output register
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, ENT_W'(size_nxt), SYM_W'(kso_r), SYM_W'(kfo_r),
                           CNT_OUT_W'(cnt_r), st_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    scan_r     <= scan_nxt;
    pend_r     <= pend_nxt;
    cpos_r     <= cpos_nxt;
    elem_r     <= elem_nxt;
    left_r     <= left_nxt;
    down_r     <= down_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    chg_r      <= chg_nxt;
    st_r       <= st_nxt;
    cnt_r      <= cnt_nxt;
    kfo_r      <= kfo_nxt;
    kso_r      <= kso_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `ASSERT_ALWAYS(a_size_bound, clk, rst_n, size_r <= SW'(HEAP_DEPTH), "entry count above depth")
  `ASSERT_ALWAYS(a_wr_in_heap, clk, rst_n, !ram_we || (SW'(ram_waddr) < size_r), "write past end")
  `ASSERT_NEXT(a_one_cmd, clk, rst_n, in_tvalid && in_tready, !in_tready, "beat taken while busy")

endmodule
